@@ sv/bptc_pkg.sv @@
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package bptc_pkg;

    typedef enum logic [2:0] {
        CAL_SENS    = 3'd0,
        CAL_OFF     = 3'd1,
        CAL_SENS_TC = 3'd2,
        CAL_OFF_TC  = 3'd3,
        CAL_TREF    = 3'd4,
        CAL_TEMP_TC = 3'd5
    } t_cal_idx;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] off;
        logic [15:0] sens_tc;
        logic [15:0] off_tc;
        logic [15:0] tref;
        logic [15:0] temp_tc;
    } t_cal;

    // first-order results
    typedef struct packed {
        logic signed [18:0] temp1;
        logic signed [17:0] q;      // temp1 - 2000
        logic               cold;
        logic               vcold;
        logic        [16:0] t2;
        logic signed [34:0] off1;
        logic signed [33:0] sens1;
        logic        [23:0] d1;
    } t_first;

    // second-order corrected results
    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [39:0] off;
        logic signed [38:0] sens;
        logic        [23:0] d1;
    } t_comp;

    localparam logic signed [18:0] TEMP_REF    = 19'sd2000;
    localparam logic signed [18:0] TEMP_VCOLD  = -19'sd1500;
    localparam logic signed [18:0] VCOLD_SPAN  = 19'sd3500;
    localparam logic signed [27:0] PRESS_MAX   = 28'sd8388607;
    localparam logic signed [27:0] PRESS_MIN   = -28'sd8388608;

endpackage

`default_nettype wire

@@ sv/bptc_cfg_regs.sv @@
// Calibration word register file, written through a plain write port.
// Depends on bptc_pkg.
`default_nettype none

module bptc_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    output bptc_pkg::t_cal     o_cal
);

    bptc_pkg::t_cal r_cal;
    bptc_pkg::t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            case (bptc_pkg::t_cal_idx'(i_cfg_idx))
                bptc_pkg::CAL_SENS:    n_cal.sens    = i_cfg_wdata;
                bptc_pkg::CAL_OFF:     n_cal.off     = i_cfg_wdata;
                bptc_pkg::CAL_SENS_TC: n_cal.sens_tc = i_cfg_wdata;
                bptc_pkg::CAL_OFF_TC:  n_cal.off_tc  = i_cfg_wdata;
                bptc_pkg::CAL_TREF:    n_cal.tref    = i_cfg_wdata;
                bptc_pkg::CAL_TEMP_TC: n_cal.temp_tc = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

@@ sv/bptc_front.sv @@
// First-order stages: dt, calibration products, first-order temp/offset/sensitivity.
// Three register stages. Depends on bptc_pkg.
`default_nettype none

module bptc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bptc_pkg::t_cal i_cal,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [23:0]   i_raw_pressure,
    input  wire logic [23:0]   i_raw_temperature,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bptc_pkg::t_first   o_data
);

    localparam int Stages = 3;

    logic [Stages-1:0] r_v;
    logic [Stages:0]   s_rdy;

    always_comb begin
        s_rdy[Stages] = i_ready;
        for (int k = Stages - 1; k >= 0; k--) begin
            s_rdy[k] = !r_v[k] || s_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                if (s_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: dt
    logic signed [24:0] r0_dt;
    logic        [23:0] r0_d1;
    logic signed [24:0] n_dt;

    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.tref, 8'h00});

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r0_dt <= n_dt;
            r0_d1 <= i_raw_pressure;
        end
    end

    // stage 1: products
    logic signed [41:0] r1_p6, r1_p4, r1_p3;
    logic        [47:0] r1_pdt;
    logic        [23:0] r1_d1;
    logic signed [41:0] n_p6, n_p4, n_p3;
    logic signed [49:0] dt_sq;

    assign n_p6  = r0_dt * $signed({1'b0, i_cal.temp_tc});
    assign n_p4  = r0_dt * $signed({1'b0, i_cal.off_tc});
    assign n_p3  = r0_dt * $signed({1'b0, i_cal.sens_tc});
    assign dt_sq = r0_dt * r0_dt;

    always_ff @(posedge i_clk) begin
        if (s_rdy[1]) begin
            r1_p6  <= n_p6;
            r1_p4  <= n_p4;
            r1_p3  <= n_p3;
            r1_pdt <= dt_sq[47:0];
            r1_d1  <= r0_d1;
        end
    end

    // stage 2: scale toward zero, first-order values
    logic signed [41:0] p6_b, p4_b, p3_b;
    logic signed [17:0] q;
    logic signed [33:0] off_t;
    logic signed [32:0] sens_t;
    bptc_pkg::t_first   n_first;
    bptc_pkg::t_first   r2_first;

    always_comb begin
        p6_b   = r1_p6 + (r1_p6[41] ? 42'sd8388607 : 42'sd0);
        p4_b   = r1_p4 + (r1_p4[41] ? 42'sd127 : 42'sd0);
        p3_b   = r1_p3 + (r1_p3[41] ? 42'sd255 : 42'sd0);
        q      = $signed(p6_b[40:23]);
        off_t  = $signed(p4_b[40:7]);
        sens_t = $signed(p3_b[40:8]);

        n_first.q     = q;
        n_first.temp1 = bptc_pkg::TEMP_REF + $signed({q[17], q});
        n_first.cold  = n_first.temp1 < bptc_pkg::TEMP_REF;
        n_first.vcold = n_first.temp1 < bptc_pkg::TEMP_VCOLD;
        n_first.t2    = r1_pdt[47:31];
        n_first.off1  = $signed({3'b000, i_cal.off, 16'h0000})
                      + $signed({off_t[33], off_t});
        n_first.sens1 = $signed({3'b000, i_cal.sens, 15'h0000})
                      + $signed({sens_t[32], sens_t});
        n_first.d1    = r1_d1;
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[2]) begin
            r2_first <= n_first;
        end
    end

    assign o_ready = s_rdy[0];
    assign o_valid = r_v[Stages-1];
    assign o_data  = r2_first;

endmodule

`default_nettype wire

@@ sv/bptc_cold.sv @@
// Second-order (cold and very cold) correction stages, four register stages.
// Depends on bptc_pkg.
`default_nettype none

module bptc_cold (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire bptc_pkg::t_first i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output bptc_pkg::t_comp      o_data
);

    localparam int Stages = 4;

    logic [Stages-1:0] r_v;
    logic [Stages:0]   s_rdy;

    always_comb begin
        s_rdy[Stages] = i_ready;
        for (int k = Stages - 1; k >= 0; k--) begin
            s_rdy[k] = !r_v[k] || s_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                if (s_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: squares
    logic signed [35:0] sq_c;
    logic signed [18:0] dv;
    logic signed [37:0] sq_v;
    logic        [33:0] r0_sqc;
    logic        [34:0] r0_sqv;
    bptc_pkg::t_first   r0_f;

    assign sq_c = i_data.q * i_data.q;
    assign dv   = $signed({i_data.q[17], i_data.q}) + bptc_pkg::VCOLD_SPAN;
    assign sq_v = dv * dv;

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r0_sqc <= sq_c[33:0];
            r0_sqv <= sq_v[34:0];
            r0_f   <= i_data;
        end
    end

    // stage 1: 5x, 7x, 11x
    logic [36:0] n_c5, r1_c5;
    logic [37:0] n_v7, r1_v7;
    logic [38:0] n_v11, r1_v11;
    bptc_pkg::t_first r1_f;

    always_comb begin
        n_c5  = {1'b0, r0_sqc, 2'b00} + {3'b000, r0_sqc};
        n_v7  = '0;
        n_v11 = '0;
        if (r0_f.vcold) begin
            n_v7  = {r0_sqv, 3'b000} - {3'b000, r0_sqv};
            n_v11 = {1'b0, r0_sqv, 3'b000} + {3'b000, r0_sqv, 1'b0} + {4'h0, r0_sqv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[1]) begin
            r1_c5  <= n_c5;
            r1_v7  <= n_v7;
            r1_v11 <= n_v11;
            r1_f   <= r0_f;
        end
    end

    // stage 2: correction sums
    logic [37:0] n_off2, r2_off2;
    logic [37:0] n_sens2, r2_sens2;
    bptc_pkg::t_first r2_f;

    assign n_off2  = {2'b00, r1_c5[36:1]} + r1_v7;
    assign n_sens2 = {3'b000, r1_c5[36:2]} + r1_v11[38:1];

    always_ff @(posedge i_clk) begin
        if (s_rdy[2]) begin
            r2_off2  <= n_off2;
            r2_sens2 <= n_sens2;
            r2_f     <= r1_f;
        end
    end

    // stage 3: apply
    logic signed [19:0] temp_w;
    bptc_pkg::t_comp    n_comp;
    bptc_pkg::t_comp    r3_comp;

    always_comb begin
        temp_w      = $signed({r2_f.temp1[18], r2_f.temp1}) - $signed({3'b000, r2_f.t2});
        n_comp.d1   = r2_f.d1;
        n_comp.temp = r2_f.temp1;
        n_comp.off  = $signed({{5{r2_f.off1[34]}}, r2_f.off1});
        n_comp.sens = $signed({{5{r2_f.sens1[33]}}, r2_f.sens1});
        if (r2_f.cold) begin
            n_comp.temp = temp_w[18:0];
            n_comp.off  = $signed({{5{r2_f.off1[34]}}, r2_f.off1})
                        - $signed({2'b00, r2_off2});
            n_comp.sens = $signed({{5{r2_f.sens1[33]}}, r2_f.sens1})
                        - $signed({1'b0, r2_sens2});
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[3]) begin
            r3_comp <= n_comp;
        end
    end

    assign o_ready = s_rdy[0];
    assign o_valid = r_v[Stages-1];
    assign o_data  = r3_comp;

endmodule

`default_nettype wire

@@ sv/bptc_press.sv @@
// Pressure stages: split d1*sens product, scaling, offset, saturation, output word.
// Five register stages. Depends on bptc_pkg.
`default_nettype none

module bptc_press (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire bptc_pkg::t_comp i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic signed [18:0]  o_temperature,
    output logic signed [23:0]  o_pressure
);

    localparam int Stages = 5;

    logic [Stages-1:0] r_v;
    logic [Stages:0]   s_rdy;

    always_comb begin
        s_rdy[Stages] = i_ready;
        for (int k = Stages - 1; k >= 0; k--) begin
            s_rdy[k] = !r_v[k] || s_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                if (s_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: partial products
    logic        [43:0] n_lo, r0_lo;
    logic signed [43:0] n_hi, r0_hi;
    logic signed [39:0] r0_off;
    logic signed [18:0] r0_temp;

    assign n_lo = i_data.d1 * i_data.sens[19:0];
    assign n_hi = $signed({1'b0, i_data.d1}) * $signed(i_data.sens[38:20]);

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r0_lo   <= n_lo;
            r0_hi   <= n_hi;
            r0_off  <= i_data.off;
            r0_temp <= i_data.temp;
        end
    end

    // stage 1: combine
    logic signed [62:0] n_prod, r1_prod;
    logic signed [39:0] r1_off;
    logic signed [18:0] r1_temp;

    assign n_prod = $signed({r0_hi[42:0], 20'h00000}) + $signed({19'h00000, r0_lo});

    always_ff @(posedge i_clk) begin
        if (s_rdy[1]) begin
            r1_prod <= n_prod;
            r1_off  <= r0_off;
            r1_temp <= r0_temp;
        end
    end

    // stage 2: divide by 2^21 toward zero
    logic signed [62:0] prod_b;
    logic signed [41:0] r2_a;
    logic signed [39:0] r2_off;
    logic signed [18:0] r2_temp;

    assign prod_b = r1_prod + (r1_prod[62] ? 63'sd2097151 : 63'sd0);

    always_ff @(posedge i_clk) begin
        if (s_rdy[2]) begin
            r2_a    <= $signed(prod_b[62:21]);
            r2_off  <= r1_off;
            r2_temp <= r1_temp;
        end
    end

    // stage 3: subtract offset
    logic signed [42:0] n_diff, r3_diff;
    logic signed [18:0] r3_temp;

    assign n_diff = $signed({r2_a[41], r2_a}) - $signed({{3{r2_off[39]}}, r2_off});

    always_ff @(posedge i_clk) begin
        if (s_rdy[3]) begin
            r3_diff <= n_diff;
            r3_temp <= r2_temp;
        end
    end

    // stage 4: divide by 2^15 toward zero, saturate, output word
    logic signed [42:0] diff_b;
    logic signed [27:0] pr;
    logic signed [23:0] n_press, r4_press;
    logic signed [18:0] r4_temp;

    always_comb begin
        diff_b = r3_diff + (r3_diff[42] ? 43'sd32767 : 43'sd0);
        pr     = $signed(diff_b[42:15]);
        if (pr > bptc_pkg::PRESS_MAX) begin
            n_press = bptc_pkg::PRESS_MAX[23:0];
        end else if (pr < bptc_pkg::PRESS_MIN) begin
            n_press = bptc_pkg::PRESS_MIN[23:0];
        end else begin
            n_press = pr[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[4]) begin
            r4_press <= n_press;
            r4_temp  <= r3_temp;
        end
    end

    assign o_ready       = s_rdy[0];
    assign o_valid       = r_v[Stages-1];
    assign o_temperature = r4_temp;
    assign o_pressure    = r4_press;

endmodule

`default_nettype wire

@@ sv/baro_pressure_temp_compensation_unit.sv @@
// Barometric sensor compensation, top level: calibration registers and pipeline.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word: a raw 24-bit pressure
//   and a raw 24-bit temperature conversion result.
//   Output channel (o_out_valid / i_out_ready) gives one word per input word:
//   temperature in 0.01 C and pressure in 0.01 mbar, saturated to 24 bits signed.
//   Six calibration words are written through i_cfg_we / i_cfg_idx / i_cfg_wdata,
//   one per cycle, while the pipeline is empty; indexes 6 and 7 are ignored.
// Timing:
//   12 register stages; one word per cycle sustained while i_out_ready is high;
//   the stage count is set by the multiplier stages (dt products, cold-correction
//   squares, split d1*sens product).
// Reset:
//   i_rst_n low clears all stage valid bits and calibration words to zero.
// Stall:
//   With i_out_ready low, words fill empty stages behind the output register;
//   o_in_ready drops only when every stage holds a word. Nothing is lost.
`default_nettype none

module baro_pressure_temp_compensation_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [23:0]   i_raw_pressure,
    input  wire logic [23:0]   i_raw_temperature,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic signed [18:0] o_temperature,
    output logic signed [23:0] o_pressure
);

    bptc_pkg::t_cal   cal;
    bptc_pkg::t_first first_w;
    bptc_pkg::t_comp  comp_w;
    logic             first_valid, first_ready;
    logic             comp_valid, comp_ready;

    bptc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cal       (cal)
    );

    bptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (cal),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (first_valid),
        .i_ready           (first_ready),
        .o_data            (first_w)
    );

    bptc_cold u_cold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (first_valid),
        .o_ready (first_ready),
        .i_data  (first_w),
        .o_valid (comp_valid),
        .i_ready (comp_ready),
        .o_data  (comp_w)
    );

    bptc_press u_press (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (comp_valid),
        .o_ready       (comp_ready),
        .i_data        (comp_w),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_temperature (o_temperature),
        .o_pressure    (o_pressure)
    );

endmodule

`default_nettype wire
